### design/stac_pkg.sv
// Shared types, codes and helpers of the shadow tag access checker.
package stac_pkg;

    localparam int TAG_ENTRIES_DEF = 65536;
    localparam int TAG_BITS        = 4;
    localparam int ADDR_W          = 32;
    localparam int LEN_W           = 17;
    localparam int SPAN_W          = ADDR_W + 1;
    localparam int SIZE_RST        = 65536;
    localparam int CFG_IDX_W       = 2;
    localparam int IN_DATA_W       = 72;
    localparam int OUT_DATA_W      = 40;

    localparam logic [TAG_BITS-1:0] TAG_FULL = 4'hf;
    localparam logic [TAG_BITS-1:0] TAG_ALL  = 4'h1;
    localparam logic [TAG_BITS-1:0] TAG_USR  = 4'h2;
    localparam logic [TAG_BITS-1:0] TAG_WRT  = 4'h4;
    localparam logic [TAG_BITS-1:0] TAG_INI  = 4'h8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE   = 2'd0,
        CFG_SIZE   = 2'd1,
        CFG_ENABLE = 2'd2,
        CFG_NONE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_ACCESS = 2'd0,
        OP_CHANGE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_IGNORE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_MISMATCH = 3'd1,
        STS_OUTSIDE  = 3'd2,
        STS_PARTIAL  = 3'd3,
        STS_SKIPPED  = 3'd4,
        STS_BAD_LEN  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_LOCATE,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  size_eff;
        logic              enable;
    } t_cfg;

    typedef struct packed {
        t_op                 op;
        logic [ADDR_W-1:0]   addr;
        logic [LEN_W-1:0]    len;
        logic                alloc;
        logic                wr;
        logic [TAG_BITS-1:0] smask;
        logic [TAG_BITS-1:0] sval;
        logic [TAG_BITS-1:0] dmask;
        logic [TAG_BITS-1:0] dval;
    } t_job;

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   faddr;
        logic [TAG_BITS-1:0] ftag;
        logic                mal;
    } t_result;

    // write or init bits set with neither access bit
    function automatic logic bad_tag(input logic [TAG_BITS-1:0] t);
        bad_tag = (t != '0) && ((t & (TAG_ALL | TAG_USR)) == '0);
    endfunction

endpackage

### design/shadow_tag_access_checker_unit.sv
// Top level of the shadow tag access checker: ports, registers and result buffer.
//
// Keeps a 4-bit tag per byte of one guarded region and checks or rewrites tags
// one operation at a time. Operations arrive on the s_axis stream (operation
// code in tuser, the other fields in tdata); one result per operation leaves on
// m_axis. Region base, size and check enable are written on the cfg channel,
// which is always ready; write it only while no operation is in flight.
// An accepted operation goes from ST_SUM to ST_LOCATE for the region tests,
// then to ST_WALK, stepping through the bytes walked (up to the first mismatch),
// then to ST_DONE; ignored operations and zero length leave ST_SUM for ST_DONE,
// and those that end at the region tests or are skipped leave ST_LOCATE for it.
// The result then passes through the output register to m_axis. The tag memory
// does one read-modify-write per byte per cycle; the next operation is taken
// only once the engine is free. After reset a clearing pass writes every tag to
// zero, one entry per cycle; s_axis_tready stays low until it ends.
// A finished result waits in the output register while the engine takes and
// works on the next operation; that one then holds until m_axis_tready frees it.
module shadow_tag_access_checker_unit
    import stac_pkg::*;
#(
    parameter int TAG_ENTRIES = TAG_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // address, length, allocator_context, is_write, smask, sval,
    // dmask, dval, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status, fault_address, found_tag, malformed_seen
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ADDR_W-1:0]     i_cfg_data
);

    localparam int SIZE_INIT = (SIZE_RST > TAG_ENTRIES) ? TAG_ENTRIES : SIZE_RST;

    t_cfg    r_cfg;
    t_job    job;
    t_result res, r_out;
    logic    r_out_valid;
    logic    eng_ready, res_valid, res_ready, start;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base     <= '0;
            r_cfg.size_eff <= LEN_W'(SIZE_INIT);
            r_cfg.enable   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BASE:   r_cfg.base <= i_cfg_data;
                CFG_SIZE: begin
                    if (32'(i_cfg_data[LEN_W-1:0]) > 32'(TAG_ENTRIES))
                        r_cfg.size_eff <= LEN_W'(TAG_ENTRIES);
                    else
                        r_cfg.size_eff <= i_cfg_data[LEN_W-1:0];
                end
                CFG_ENABLE: r_cfg.enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign job.op    = t_op'(s_axis_tuser);
    assign job.addr  = s_axis_tdata[31:0];
    assign job.len   = s_axis_tdata[48:32];
    assign job.alloc = s_axis_tdata[49];
    assign job.wr    = s_axis_tdata[50];
    assign job.smask = s_axis_tdata[54:51];
    assign job.sval  = s_axis_tdata[58:55];
    assign job.dmask = s_axis_tdata[62:59];
    assign job.dval  = s_axis_tdata[66:63];

    assign s_axis_tready = eng_ready;
    assign start         = s_axis_tvalid && eng_ready;

    stac_engine #(
        .TAG_ENTRIES (TAG_ENTRIES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_start     (start),
        .i_job       (job),
        .o_ready     (eng_ready),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) r_out <= res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.mal, r_out.ftag, r_out.faddr, r_out.status};

endmodule

### design/stac_engine.sv
// Tag memory with clearing pass, region test and per-byte read-modify-write walk.
module stac_engine
    import stac_pkg::*;
#(
    parameter int TAG_ENTRIES = TAG_ENTRIES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_start,
    input  t_job    i_job,
    output logic    o_ready,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    localparam int AW = $clog2(TAG_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(TAG_ENTRIES - 1);

    logic [TAG_BITS-1:0] mem [TAG_ENTRIES];

    t_state              r_state, n_state;
    t_job                r_job;
    t_result             r_res, n_res;
    logic [SPAN_W-1:0]   r_end, r_hi;
    logic [AW-1:0]       r_bidx;
    logic [TAG_BITS-1:0] r_emask, r_eval;
    logic [AW-1:0]       r_idx, n_idx;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [LEN_W-1:0]    r_remain, n_remain;
    logic [AW-1:0]       r_clr;
    logic [TAG_BITS-1:0] r_rd_data;

    logic                rd_en, we;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [TAG_BITS-1:0] wr_data;

    logic                outside, in_region, disabled, mismatch, last_byte;
    logic [SPAN_W-1:0]   lo, start;
    logic [TAG_BITS-1:0] ctx, acc_mask;

    assign lo        = {1'b0, i_cfg.base};
    assign start     = {1'b0, r_job.addr};
    assign outside   = (r_end <= lo) || (r_hi <= start);
    assign in_region = (lo <= start) && (r_end <= r_hi);
    assign disabled  = (r_job.op == OP_ACCESS) && !i_cfg.enable;
    assign mismatch  = (r_rd_data & r_emask) != (r_eval & r_emask);
    assign last_byte = (r_remain == LEN_W'(1));
    assign ctx       = r_job.alloc ? TAG_ALL : TAG_USR;
    assign acc_mask  = ctx | (r_job.wr ? TAG_WRT : TAG_INI);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == LAST_IDX) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) n_state = ST_SUM;
            end
            ST_SUM: begin
                if (r_job.op == OP_IGNORE || r_job.len == '0) n_state = ST_DONE;
                else n_state = ST_LOCATE;
            end
            ST_LOCATE: begin
                if (outside || !in_region || disabled) n_state = ST_DONE;
                else n_state = ST_WALK;
            end
            ST_WALK: begin
                if (mismatch || last_byte) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = r_idx;
        we       = 1'b0;
        wr_addr  = r_idx;
        wr_data  = r_rd_data;
        n_res    = r_res;
        n_idx    = r_idx;
        n_addr   = r_addr;
        n_remain = r_remain;
        unique case (r_state)
            ST_CLEAR: begin
                we      = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
            end
            ST_IDLE: begin
                n_res.status = STS_OK;
                n_res.faddr  = '0;
                n_res.ftag   = '0;
                n_res.mal    = (i_job.op == OP_CHANGE) ? (bad_tag(i_job.dval) ||
                                                          bad_tag(i_job.sval))
                             : (i_job.op == OP_CHECK)  ? bad_tag(i_job.sval) : 1'b0;
            end
            ST_SUM: begin
                if (r_job.op == OP_IGNORE) n_res.status = STS_SKIPPED;
                else if (r_job.len == '0) n_res.status = STS_BAD_LEN;
            end
            ST_LOCATE: begin
                if (outside) begin
                    n_res.status = STS_OUTSIDE;
                end else if (!in_region) begin
                    n_res.status = STS_PARTIAL;
                end else if (disabled) begin
                    n_res.status = STS_SKIPPED;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = r_bidx;
                    n_idx    = r_bidx;
                    n_addr   = r_job.addr;
                    n_remain = r_job.len;
                end
            end
            ST_WALK: begin
                if (r_job.op != OP_CHANGE && bad_tag(r_rd_data)) n_res.mal = 1'b1;
                if (mismatch) begin
                    n_res.status = STS_MISMATCH;
                    n_res.faddr  = r_addr;
                    n_res.ftag   = r_rd_data;
                end else begin
                    if (r_job.op == OP_ACCESS && r_job.wr) begin
                        we      = 1'b1;
                        wr_data = r_rd_data | TAG_INI;
                    end else if (r_job.op == OP_CHANGE) begin
                        we      = 1'b1;
                        wr_data = (r_rd_data & ~r_job.dmask) | (r_job.dval & r_job.dmask);
                    end
                    if (!last_byte) begin
                        rd_en    = 1'b1;
                        rd_addr  = r_idx + AW'(1);
                        n_idx    = r_idx + AW'(1);
                        n_addr   = r_addr + ADDR_W'(1);
                        n_remain = r_remain - LEN_W'(1);
                    end
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) r_job <= i_job;
        if (r_state == ST_SUM) begin
            r_end  <= {1'b0, r_job.addr} + SPAN_W'(r_job.len);
            r_hi   <= {1'b0, i_cfg.base} + SPAN_W'(i_cfg.size_eff);
            r_bidx <= AW'(r_job.addr - i_cfg.base);
            if (r_job.op == OP_ACCESS) begin
                r_emask <= acc_mask;
                r_eval  <= acc_mask;
            end else begin
                r_emask <= r_job.smask;
                r_eval  <= r_job.sval;
            end
        end
        r_res    <= n_res;
        r_idx    <= n_idx;
        r_addr   <= n_addr;
        r_remain <= n_remain;
    end

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && rd_en) |-> (wr_addr != rd_addr))
        else $error("tag write and read hit the same entry");

    a_walk_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> $past(rd_en))
        else $error("walk step without a tag read issued");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == ST_IDLE) |=> (r_state == ST_SUM))
        else $error("accepted operation not started");

    a_walk_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && n_state == ST_DONE) |=>
        (r_res.status == STS_OK || r_res.status == STS_MISMATCH))
        else $error("walk ended with a region status");

endmodule
